// ===== design/ofbd_pkg.sv =====
// package for the overwriting sample ring buffer with batch drain
// sizes, operation and result codes, shared structs and helpers; no dependencies
`timescale 1ns / 1ps

package ofbd_pkg;

  localparam int DEPTH     = 64;
  localparam int BATCH_MAX = 16;
  localparam int DATA_W    = 32;

  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int LIM_W  = $clog2(BATCH_MAX + 1);

  localparam int FUNC_W   = 2;
  localparam int SAMPLE_W = 32;
  localparam int ENTRY_W  = 32;
  localparam int FCNT_W   = 7;
  localparam int TICK_W   = 16;
  localparam int LIMIT_W  = 5;
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = 16;

  localparam logic [TICK_W-1:0]  MIN_INTERVAL_RST = 16'd200;
  localparam logic [LIMIT_W-1:0] BATCH_LIMIT_RST  = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_DRAIN = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_BATCH  = 2'd1,
    KIND_REFUSE = 2'd2
  } kind_t;

  typedef enum logic {
    REASON_EMPTY = 1'b0,
    REASON_WAIT  = 1'b1
  } reason_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MIN_INTERVAL = 2'd0,
    CFG_BATCH_LIMIT  = 2'd1
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  typedef struct packed {
    logic [TICK_W-1:0]  min_interval;
    logic [LIMIT_W-1:0] batch_limit;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic              strobe;
    kind_t             kind;
    logic              last;
    logic              overwrote;
    reason_t           reason;
    logic [FILL_W-1:0] fill;
  } res_t;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== design/ofbd_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module ofbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ofbd_ctrl.sv =====
// sequencer for push, tick and batch drain; keeps pointers, fill and tick count
// depends on ofbd_pkg
`timescale 1ns / 1ps

module ofbd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ofbd_pkg::FUNC_W-1:0]   func,
  input  logic [ofbd_pkg::SAMPLE_W-1:0] sample,
  input  logic                          sink_ok,
  input  ofbd_pkg::cfg_t                cfg,
  output ofbd_pkg::mem_req_t            mem,
  output ofbd_pkg::res_t                res
);

  import ofbd_pkg::*;

  state_t             state, state_next;
  logic [AW-1:0]      read_ptr, read_ptr_next;
  logic [AW-1:0]      write_ptr, write_ptr_next;
  logic [FILL_W-1:0]  fill, fill_next;
  logic [TICK_W-1:0]  ticks, ticks_next;
  logic [LIM_W-1:0]   remain, remain_next;
  res_t               res_next;

  logic               accept;
  logic [LIM_W-1:0]   lim;
  logic [LIM_W-1:0]   n;
  logic               full;

  assign accept = start && !busy;
  assign busy   = (state == ST_DRAIN);
  assign full   = (fill == FILL_W'(DEPTH));

  always_comb begin
    if (cfg.batch_limit == '0) begin
      lim = LIM_W'(1);
    end else if (32'(cfg.batch_limit) > BATCH_MAX) begin
      lim = LIM_W'(BATCH_MAX);
    end else begin
      lim = LIM_W'(cfg.batch_limit);
    end
    if (32'(fill) < 32'(lim)) begin
      n = LIM_W'(fill);
    end else begin
      n = lim;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && func == FUNC_DRAIN && fill != '0 && ticks >= cfg.min_interval
            && n > LIM_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (remain == LIM_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    read_ptr_next  = read_ptr;
    write_ptr_next = write_ptr;
    fill_next      = fill;
    ticks_next     = ticks;
    remain_next    = remain;
    mem            = '0;
    res_next       = '0;
    res_next.kind  = KIND_PUSH;
    res_next.reason = REASON_EMPTY;
    res_next.fill  = fill;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (func)
            FUNC_PUSH: begin
              mem.we         = 1'b1;
              mem.waddr      = write_ptr;
              mem.wdata      = DATA_W'(sample);
              write_ptr_next = ptr_inc(write_ptr);
              if (full) begin
                read_ptr_next = ptr_inc(read_ptr);
              end else begin
                fill_next = fill + 1'b1;
              end
              res_next.strobe    = 1'b1;
              res_next.kind      = KIND_PUSH;
              res_next.last      = 1'b1;
              res_next.overwrote = full;
              res_next.fill      = fill_next;
            end
            FUNC_TICK: begin
              if (ticks != '1) begin
                ticks_next = ticks + 1'b1;
              end
            end
            FUNC_DRAIN: begin
              if (fill == '0) begin
                res_next.strobe = 1'b1;
                res_next.kind   = KIND_REFUSE;
                res_next.last   = 1'b1;
                res_next.reason = REASON_EMPTY;
              end else if (ticks < cfg.min_interval) begin
                res_next.strobe = 1'b1;
                res_next.kind   = KIND_REFUSE;
                res_next.last   = 1'b1;
                res_next.reason = REASON_WAIT;
              end else begin
                mem.re        = 1'b1;
                mem.raddr     = read_ptr;
                read_ptr_next = ptr_inc(read_ptr);
                fill_next     = fill - 1'b1;
                remain_next   = n - 1'b1;
                if (sink_ok) begin
                  ticks_next = '0;
                end
                res_next.strobe = 1'b1;
                res_next.kind   = KIND_BATCH;
                res_next.last   = (n == LIM_W'(1));
                res_next.fill   = fill_next;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        mem.re          = 1'b1;
        mem.raddr       = read_ptr;
        read_ptr_next   = ptr_inc(read_ptr);
        fill_next       = fill - 1'b1;
        remain_next     = remain - 1'b1;
        res_next.strobe = 1'b1;
        res_next.kind   = KIND_BATCH;
        res_next.last   = (remain == LIM_W'(1));
        res_next.fill   = fill_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      read_ptr   <= '0;
      write_ptr  <= '0;
      fill       <= '0;
      ticks      <= '0;
      remain     <= '0;
      res        <= '0;
    end else begin
      state      <= state_next;
      read_ptr   <= read_ptr_next;
      write_ptr  <= write_ptr_next;
      fill       <= fill_next;
      ticks      <= ticks_next;
      remain     <= remain_next;
      res        <= res_next;
    end
  end

endmodule

// ===== design/overwrite_fifo_batch_drain.sv =====
// top level of the overwriting sample ring buffer with rate limited batch drain
// depends on ofbd_pkg, ofbd_ram and ofbd_ctrl
`timescale 1ns / 1ps
//
// channel   handshake              payload
// command   start, busy            func, sample, sink_ok
// result    strobe (no stall)      kind, entry, last, overwrote, refuse_reason, fill_count
// config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// push, tick and refused drain never raise busy; results are registered; a tick has none
// an accepted drain of n words reads the ram once a cycle and keeps busy high for its reads
// after the start cycle; each word appears in the cycle after its read, last set on the final one
// the ram read port, one read per cycle, sets the drain rate
// synchronous reset clears pointers, fill, tick count and config to defaults
// ram contents are not cleared; the receiver cannot stall results

module overwrite_fifo_batch_drain (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ofbd_pkg::FUNC_W-1:0]   func,
  input  logic [ofbd_pkg::SAMPLE_W-1:0] sample,
  input  logic                          sink_ok,
  output logic                          strobe,
  output logic [1:0]                    kind,
  output logic [ofbd_pkg::ENTRY_W-1:0]  entry,
  output logic                          last,
  output logic                          overwrote,
  output logic                          refuse_reason,
  output logic [ofbd_pkg::FCNT_W-1:0]   fill_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ofbd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [ofbd_pkg::CDATA_W-1:0]  cfg_data
);

  import ofbd_pkg::*;

  cfg_t              cfg;
  mem_req_t          mem;
  res_t              res;
  logic [DATA_W-1:0] rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_interval <= MIN_INTERVAL_RST;
      cfg.batch_limit  <= BATCH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MIN_INTERVAL) begin
        cfg.min_interval <= TICK_W'(cfg_data);
      end else if (cfg_index == CFG_BATCH_LIMIT) begin
        cfg.batch_limit <= LIMIT_W'(cfg_data);
      end
    end
  end

  ofbd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .func    (func),
    .sample  (sample),
    .sink_ok (sink_ok),
    .cfg     (cfg),
    .mem     (mem),
    .res     (res)
  );

  ofbd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  assign strobe        = res.strobe;
  assign kind          = res.kind;
  assign entry         = (res.kind == KIND_BATCH) ? ENTRY_W'(rdata) : '0;
  assign last          = res.last;
  assign overwrote     = res.overwrote;
  assign refuse_reason = res.reason;
  assign fill_count    = FCNT_W'(res.fill);

endmodule
